@@ hdl/hex_literal_prefix_parser_core_defines.svh @@
// Assertion macros shared by the hex literal parser RTL.
`ifndef HEX_LITERAL_PREFIX_PARSER_CORE_DEFINES_SVH
`define HEX_LITERAL_PREFIX_PARSER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HLPP_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HLPP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/hlpp_pkg.sv @@
// Package with the phase codes, character constants and digit decoder of the hex parser.
package hlpp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned NumberW = 64;
  localparam int unsigned PhaseW  = 3;

  // Parser phase codes.
  localparam logic [PhaseW-1:0] PH_SKIP     = 3'd0;
  localparam logic [PhaseW-1:0] PH_PREFIX_X = 3'd1;
  localparam logic [PhaseW-1:0] PH_DIGITS   = 3'd2;
  localparam logic [PhaseW-1:0] PH_DONE     = 3'd3;
  localparam logic [PhaseW-1:0] PH_FAIL     = 3'd4;

  // Character codes.
  localparam logic [CharW-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CharW-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CharW-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CHAR_APOS    = 8'h27;
  localparam logic [CharW-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CharW-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CHAR_UPPER_F = 8'h46;
  localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CHAR_LOWER_F = 8'h66;
  localparam logic [CharW-1:0] CHAR_LOWER_X = 8'h78;

  // Offsets that map a letter digit onto its value in the low nibble.
  localparam logic [CharW-1:0] UPPER_OFFSET = 8'h37;
  localparam logic [CharW-1:0] LOWER_OFFSET = 8'h57;

  // Decoded digit: bit 4 flags a character that is not a hex digit.
  typedef logic [4:0] digit_t;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  function automatic digit_t hex_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] diff;
    diff = '0;
    if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
      diff = c - CHAR_ZERO;
      return {1'b0, diff[3:0]};
    end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
      diff = c - UPPER_OFFSET;
      return {1'b0, diff[3:0]};
    end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
      diff = c - LOWER_OFFSET;
      return {1'b0, diff[3:0]};
    end
    return 5'h10;
  endfunction

endpackage

@@ hdl/hlpp_channels.sv @@
// Valid/ready channel interfaces for characters in and parse results out.
interface hlpp_char_if;
  logic                     valid;
  logic                     ready;
  logic [hlpp_pkg::CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface hlpp_result_if;
  logic                       valid;
  logic                       ready;
  logic                       is_valid;
  logic [hlpp_pkg::NumberW-1:0] number;

  modport source (output valid, output is_valid, output number, input ready);
  modport sink   (input valid, input is_valid, input number, output ready);
endinterface

@@ hdl/hex_literal_prefix_parser_core.sv @@
// Streaming parser that turns NUL-terminated "0x" hex literals into integers.
//
// Usage:
//   char_i carries one character per transfer; a NUL character ends a string.
//   result_o carries one result per string, made when its NUL is processed:
//   is_valid is set when the string held a well-formed 0x hex literal, and
//   number holds its low VALUE_WIDTH bits, zero-extended, or 0 when invalid.
// Timing:
//   A character is captured in an input register and processed there, when
//   the phase and accumulator are updated. A NUL passes through the input
//   register and then the result register before its result is on result_o.
//   One character is taken every cycle; only the result register limits it.
// Stall:
//   While a result waits in the output register, non-NUL characters keep
//   flowing. A NUL waits in the input register until the result register
//   frees, and char_i.ready drops only while that NUL is held there.
// Reset:
//   rst_ni clears both registers' valid flags and returns the parser to
//   skipping leading blanks with an empty accumulator.
module hex_literal_prefix_parser_core #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  hlpp_char_if.sink      char_i,
  hlpp_result_if.source  result_o
);
  import hlpp_pkg::*;

  `include "hex_literal_prefix_parser_core_defines.svh"

  // Input register.
  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_fire;
  logic             in_is_nul;

  // Parser state.
  logic [PhaseW-1:0]      phase_q, phase_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   seen_q, seen_d;

  // Result register.
  logic                   out_valid_q;
  logic                   out_is_valid_q, out_is_valid_d;
  logic [VALUE_WIDTH-1:0] out_number_q, out_number_d;
  logic [NumberW-1:0]     number_ext;

  digit_t digit;
  logic   ok;

  assign in_is_nul = (in_char_q == CHAR_NUL);
  // A NUL may only move on once the result register can take its result.
  assign in_fire = in_valid_q && (!in_is_nul || !out_valid_q || result_o.ready);
  assign char_i.ready = !in_valid_q || in_fire;

  // Capture the incoming character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q <= char_i.char_code;
    end
  end

  // Phase and accumulator update for the character in the input register.
  always_comb begin
    digit          = hex_value(in_char_q);
    ok             = (phase_q == PH_DONE) || ((phase_q == PH_DIGITS) && seen_q);
    phase_d        = phase_q;
    acc_d          = acc_q;
    seen_d         = seen_q;
    out_is_valid_d = ok;
    out_number_d   = ok ? acc_q : '0;
    if (in_is_nul) begin
      phase_d = PH_SKIP;
      acc_d   = '0;
      seen_d  = 1'b0;
    end else begin
      unique case (phase_q)
        PH_SKIP: begin
          if (!is_blank(in_char_q)) begin
            phase_d = (in_char_q == CHAR_ZERO) ? PH_PREFIX_X : PH_FAIL;
          end
        end
        PH_PREFIX_X: begin
          if (in_char_q == CHAR_LOWER_X) begin
            phase_d = PH_DIGITS;
            acc_d   = '0;
            seen_d  = 1'b0;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          priority if (!digit[4]) begin
            acc_d  = {acc_q[VALUE_WIDTH-5:0], digit[3:0]};
            seen_d = 1'b1;
          end else if ((in_char_q == CHAR_APOS) && seen_q) begin
            // Separator after a digit: nothing changes.
          end else if (is_blank(in_char_q)) begin
            phase_d = seen_q ? PH_DONE : PH_FAIL;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_DONE: begin
          // Characters after the terminator are ignored.
        end
        default: begin
          phase_d = PH_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      acc_q   <= '0;
      seen_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
    end
  end

  // Result register, loaded when a NUL is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && in_is_nul) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_is_nul) begin
      out_is_valid_q <= out_is_valid_d;
      out_number_q   <= out_number_d;
    end
  end

  // Zero-extend the value to the result field width.
  always_comb begin
    number_ext                  = '0;
    number_ext[VALUE_WIDTH-1:0] = out_number_q;
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.is_valid = out_is_valid_q;
  assign result_o.number   = number_ext;

  // A failed string never reports a value.
  `HLPP_ASSERT_SAME(a_invalid_zero, out_valid_q && !out_is_valid_q, out_number_q == '0, "invalid result carries a nonzero number")
  // The done phase is only reached after a digit.
  `HLPP_ASSERT_SAME(a_done_has_digit, phase_q == PH_DONE, seen_q, "done phase without a digit")
  // A processed NUL returns the parser to its reset state.
  `HLPP_ASSERT_NEXT(a_nul_clears, in_fire && in_is_nul, (phase_q == PH_SKIP) && !seen_q && (acc_q == '0), "state not cleared after end of string")
  // A well-formed literal yields a valid result in the next cycle.
  `HLPP_ASSERT_NEXT(a_good_result, in_fire && in_is_nul && ok, out_valid_q && out_is_valid_q, "well-formed literal not reported as valid")

endmodule
